// ===== hdl/vqfl_pkg.sv =====
`default_nettype none

package vqfl_pkg;

  localparam int LOG2_QUEUE_DEPTH = 6;
  localparam int QUEUE_DEPTH      = 1 << LOG2_QUEUE_DEPTH;
  localparam int IDX_W            = LOG2_QUEUE_DEPTH;
  localparam int CNT_W            = LOG2_QUEUE_DEPTH + 1;

  localparam logic [IDX_W-1:0] IDX_MASK   = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_LINK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESP
  } state_t;

  // One descriptor table entry
  typedef struct packed {
    logic [IDX_W-1:0] next_link;
    logic             chain_flag;
    logic             write_flag;
  } desc_entry_t;

endpackage

`default_nettype wire

// ===== hdl/vqfl_in_if.sv =====
`default_nettype none

interface vqfl_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [vqfl_pkg::IDX_W-1:0] index;
  logic [vqfl_pkg::IDX_W-1:0] link_target;
  logic                      writable;

  modport source (
    output valid, operation, index, link_target, writable,
    input  ready
  );

  modport sink (
    input  valid, operation, index, link_target, writable,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/vqfl_out_if.sv =====
`default_nettype none

interface vqfl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [vqfl_pkg::IDX_W-1:0] granted_index;
  logic [vqfl_pkg::CNT_W-1:0] freed_cnt;
  logic [vqfl_pkg::CNT_W-1:0] free_remaining;

  modport source (
    output valid, status, granted_index, freed_cnt, free_remaining,
    input  ready
  );

  modport sink (
    input  valid, status, granted_index, freed_cnt, free_remaining,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/vqfl_ram.sv =====
`default_nettype none

module vqfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/virtqueue_descriptor_free_list.sv =====
// Descriptor free list for a split virtqueue table of 64 entries.
// in_ch carries one operation per transaction: allocate, link, free chain,
// or no-op (operation 3). out_ch returns exactly one result per operation.
// Both channels use valid/ready; a transaction completes when both are high.
// A no-op or a failed allocate goes from acceptance straight to the result
// state; allocate and link do one table read and one write, and freeing a
// chain of n descriptors (n up to 64) walks the chain first. Each chain step
// is one read of the descriptor table, which has a single synchronous port.
// One operation is in flight at a time; in_ch.ready returns at the clock
// edge that loads the result into the output register.
// A finished result waits in the output register while the next operation
// is accepted and worked on; if the receiver stalls, the block holds the
// following result until the output register frees up.
// Reset clears per-entry valid bits; an entry never written reads as its
// reset value (next = i + 1, flags clear). No clearing pass is needed, so
// in_ch.ready is high in the first cycle after reset.
`default_nettype none

module virtqueue_descriptor_free_list (
  input  wire logic   clk,
  input  wire logic   rst_n,
  vqfl_in_if.sink     in_ch,
  vqfl_out_if.source  out_ch
);

  localparam int IW = vqfl_pkg::IDX_W;
  localparam int CW = vqfl_pkg::CNT_W;

  vqfl_pkg::state_t      state_r, state_nxt;
  vqfl_pkg::op_t         op_r, op_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         tgt_r, tgt_nxt;
  logic                  wr_r, wr_nxt;
  logic [IW-1:0]         free_head_r, free_head_nxt;
  logic [CW-1:0]         free_total_r, free_total_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         addr_q_r, addr_q_nxt;
  logic                  vld_q_r, vld_q_nxt;
  logic [vqfl_pkg::QUEUE_DEPTH-1:0] valid_r, valid_nxt;

  logic                  status_r, status_nxt;
  logic [IW-1:0]         granted_r, granted_nxt;
  logic [CW-1:0]         freed_r, freed_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [IW-1:0]         out_granted_r, out_granted_nxt;
  logic [CW-1:0]         out_freed_r, out_freed_nxt;
  logic [CW-1:0]         out_remain_r, out_remain_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic                  walk_more;
  logic [CW:0]           total_sum;

  logic [IW-1:0]         rd_addr;
  logic                  ram_we;
  vqfl_pkg::desc_entry_t ram_wdata;
  vqfl_pkg::desc_entry_t ram_q;
  vqfl_pkg::desc_entry_t entry;

  vqfl_ram #(
    .WIDTH ($bits(vqfl_pkg::desc_entry_t)),
    .DEPTH (vqfl_pkg::QUEUE_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q_r),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign in_ch.ready          = (state_r == vqfl_pkg::ST_IDLE);
  assign in_acc               = in_ch.valid && in_ch.ready;
  assign out_free             = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.granted_index  = out_granted_r;
  assign out_ch.freed_cnt      = out_freed_r;
  assign out_ch.free_remaining = out_remain_r;

  // Unwritten entries read as their reset contents
  always_comb begin
    if (vld_q_r) begin
      entry = ram_q;
    end else begin
      entry.next_link  = IW'(addr_q_r + 1'b1);
      entry.chain_flag = 1'b0;
      entry.write_flag = 1'b0;
    end
  end

  assign walk_more = entry.chain_flag && (count_r < vqfl_pkg::DEPTH_CNT);
  assign total_sum = {1'b0, free_total_r} + {1'b0, count_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vqfl_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (vqfl_pkg::op_t'(in_ch.operation) == vqfl_pkg::OP_NOP ||
              (vqfl_pkg::op_t'(in_ch.operation) == vqfl_pkg::OP_ALLOC &&
               free_total_r == '0)) begin
            state_nxt = vqfl_pkg::ST_RESP;
          end else begin
            state_nxt = vqfl_pkg::ST_EVAL;
          end
        end
      end
      vqfl_pkg::ST_EVAL: begin
        if (!(op_r == vqfl_pkg::OP_FREE && walk_more)) begin
          state_nxt = vqfl_pkg::ST_RESP;
        end
      end
      vqfl_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = vqfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vqfl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and table accesses
  always_comb begin
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    tgt_nxt         = tgt_r;
    wr_nxt          = wr_r;
    free_head_nxt   = free_head_r;
    free_total_nxt  = free_total_r;
    count_nxt       = count_r;
    status_nxt      = status_r;
    granted_nxt     = granted_r;
    freed_nxt       = freed_r;
    valid_nxt       = valid_r;
    rd_addr         = free_head_r;
    ram_we          = 1'b0;
    ram_wdata       = entry;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_freed_nxt   = out_freed_r;
    out_remain_nxt  = out_remain_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    unique case (state_r)
      vqfl_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = vqfl_pkg::op_t'(in_ch.operation);
          idx_nxt     = in_ch.index;
          tgt_nxt     = in_ch.link_target;
          wr_nxt      = in_ch.writable;
          status_nxt  = 1'b0;
          granted_nxt = '0;
          freed_nxt   = '0;
          count_nxt   = CW'(1);
          case (vqfl_pkg::op_t'(in_ch.operation)) inside
            vqfl_pkg::OP_ALLOC: begin
              rd_addr = free_head_r;
              if (free_total_r == '0) begin
                status_nxt = 1'b1;
              end
            end
            vqfl_pkg::OP_LINK, vqfl_pkg::OP_FREE: rd_addr = in_ch.index;
            default: rd_addr = free_head_r;
          endcase
        end
      end
      vqfl_pkg::ST_EVAL: begin
        case (op_r)
          vqfl_pkg::OP_ALLOC: begin
            ram_we               = 1'b1;
            ram_wdata.next_link  = vqfl_pkg::IDX_MASK;
            ram_wdata.chain_flag = 1'b0;
            ram_wdata.write_flag = wr_r;
            free_head_nxt        = entry.next_link;
            free_total_nxt       = free_total_r - 1'b1;
            granted_nxt          = addr_q_r;
          end
          vqfl_pkg::OP_LINK: begin
            ram_we               = 1'b1;
            ram_wdata.next_link  = tgt_r;
            ram_wdata.chain_flag = 1'b1;
          end
          vqfl_pkg::OP_FREE: begin
            if (walk_more) begin
              rd_addr   = entry.next_link;
              count_nxt = count_r + 1'b1;
            end else begin
              // splice: tail points at old head, chain head becomes new head
              ram_we              = 1'b1;
              ram_wdata.next_link = free_head_r;
              free_head_nxt       = idx_r;
              free_total_nxt      = (total_sum > {1'b0, vqfl_pkg::DEPTH_CNT}) ?
                                    vqfl_pkg::DEPTH_CNT : total_sum[CW-1:0];
              freed_nxt           = count_r;
            end
          end
          default: ram_we = 1'b0;
        endcase
      end
      vqfl_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_freed_nxt   = freed_r;
          out_remain_nxt  = free_total_r;
        end
      end
      default: ram_we = 1'b0;
    endcase

    if (ram_we) begin
      valid_nxt[addr_q_r] = 1'b1;
    end
  end

  assign addr_q_nxt = rd_addr;
  assign vld_q_nxt  = valid_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vqfl_pkg::ST_IDLE;
      free_head_r  <= '0;
      free_total_r <= vqfl_pkg::DEPTH_CNT;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    idx_r         <= idx_nxt;
    tgt_r         <= tgt_nxt;
    wr_r          <= wr_nxt;
    count_r       <= count_nxt;
    addr_q_r      <= addr_q_nxt;
    vld_q_r       <= vld_q_nxt;
    status_r      <= status_nxt;
    granted_r     <= granted_nxt;
    freed_r       <= freed_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_freed_r   <= out_freed_nxt;
    out_remain_r  <= out_remain_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

  localparam int IDX_W       = vqfl_pkg::IDX_W;
  localparam int CNT_W       = vqfl_pkg::CNT_W;
  localparam int QUEUE_DEPTH = vqfl_pkg::QUEUE_DEPTH;

  localparam int ITEM_TARGET  = 1850;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 80;
  localparam int STALL_LIMIT  = 4000;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] freed;
    logic [CNT_W-1:0] remaining;
  } op_result_t;

  logic clk = 1'b0;
  logic rst_n;

  vqfl_in_if  in_ch();
  vqfl_out_if out_ch();

  virtqueue_descriptor_free_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the descriptor table and free list
  logic [IDX_W-1:0] desc_next [QUEUE_DEPTH];
  logic             desc_chained [QUEUE_DEPTH];
  logic             desc_writable [QUEUE_DEPTH];
  logic [IDX_W-1:0] list_head;
  int               list_count;

  op_result_t awaited_results[$];
  int mismatch_count = 0;
  int ops_issued = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  int hold_seq = 0;
  int idle_cycles = 0;

  function automatic op_result_t apply_descriptor_op(vqfl_pkg::op_t op,
                                                     logic [IDX_W-1:0] idx,
                                                     logic [IDX_W-1:0] tgt, logic wr);
    op_result_t r;
    logic [IDX_W-1:0] tail;
    int walked;
    r = '0;
    case (op)
      vqfl_pkg::OP_ALLOC: begin
        if (list_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.granted = list_head;
          list_count--;
          list_head = desc_next[r.granted];
          desc_chained[r.granted] = 1'b0;
          desc_writable[r.granted] = wr;
          desc_next[r.granted] = vqfl_pkg::IDX_MASK;
        end
      end
      vqfl_pkg::OP_LINK: begin
        desc_chained[idx] = 1'b1;
        desc_next[idx] = tgt;
      end
      vqfl_pkg::OP_FREE: begin
        tail = idx;
        walked = 1;
        // a cyclic chain stops after a full table's worth of steps
        while (desc_chained[tail] && walked < QUEUE_DEPTH) begin
          tail = desc_next[tail];
          walked++;
        end
        desc_next[tail] = list_head;
        list_head = idx;
        list_count = (list_count + walked > QUEUE_DEPTH) ? QUEUE_DEPTH : list_count + walked;
        r.freed = CNT_W'(walked);
      end
      default: ;
    endcase
    r.remaining = CNT_W'(list_count);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, QUEUE_DEPTH - 1));
  endfunction

  task automatic send_op(input vqfl_pkg::op_t op, input logic [IDX_W-1:0] idx,
                         input logic [IDX_W-1:0] tgt, input logic wr,
                         output op_result_t res);
    int gap;
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.operation   = op;
    in_ch.index       = idx;
    in_ch.link_target = tgt;
    in_ch.writable    = wr;
    do @(posedge clk); while (!in_ch.ready);
    res = apply_descriptor_op(op, idx, tgt, wr);
    awaited_results.push_back(res);
    ops_issued++;
    if (burst_left > 0 || sender_steady) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk) in_ch.valid = 1'b0;
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
    end
  endtask

  task automatic wait_for_results();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    op_result_t res;
    send_op(vqfl_pkg::OP_ALLOC, '0, '0, 1'b1, res);
    send_op(vqfl_pkg::OP_ALLOC, '1, '1, 1'b0, res);
    send_op(vqfl_pkg::OP_ALLOC, '0, '1, 1'b1, res);
    send_op(vqfl_pkg::OP_LINK, 6'd0, 6'd1, 1'b0, res);
    send_op(vqfl_pkg::OP_LINK, 6'd1, 6'd2, 1'b1, res);
    send_op(vqfl_pkg::OP_FREE, 6'd0, '1, 1'b1, res);
    send_op(vqfl_pkg::OP_NOP, '1, '1, 1'b1, res);
    send_op(vqfl_pkg::OP_NOP, '0, '0, 1'b0, res);
    send_op(vqfl_pkg::OP_ALLOC, '1, '0, 1'b0, res);
    send_op(vqfl_pkg::OP_ALLOC, '0, '0, 1'b1, res);
    send_op(vqfl_pkg::OP_LINK, '1, '0, 1'b0, res);
    send_op(vqfl_pkg::OP_LINK, '0, '1, 1'b1, res);
    send_op(vqfl_pkg::OP_FREE, res.granted, '0, 1'b0, res);
    // self-linked descriptor: runaway walk
    send_op(vqfl_pkg::OP_ALLOC, '0, '0, 1'b0, res);
    send_op(vqfl_pkg::OP_LINK, res.granted, res.granted, 1'b0, res);
    send_op(vqfl_pkg::OP_FREE, in_ch.index, '0, 1'b1, res);
    // descriptor that was never handed out: count saturates
    send_op(vqfl_pkg::OP_FREE, '1, '1, 1'b0, res);
    send_op(vqfl_pkg::OP_FREE, 6'd40, '0, 1'b1, res);
  endtask

  task automatic test_exhaust();
    op_result_t res;
    logic [IDX_W-1:0] members[$];
    int len, k;
    do begin
      send_op(vqfl_pkg::OP_ALLOC, rand_idx(), rand_idx(), 1'($urandom_range(0, 1)), res);
      if (res.status == STATUS_DONE) members.push_back(res.granted);
    end while (res.status == STATUS_DONE);
    send_op(vqfl_pkg::OP_ALLOC, rand_idx(), rand_idx(), 1'b1, res);
    while (members.size() != 0) begin
      len = $urandom_range(1, (members.size() < 8) ? members.size() : 8);
      for (k = 0; k + 1 < len; k++)
        send_op(vqfl_pkg::OP_LINK, members[k], members[k + 1],
                1'($urandom_range(0, 1)), res);
      send_op(vqfl_pkg::OP_FREE, members[0], rand_idx(), 1'($urandom_range(0, 1)), res);
      repeat (len) void'(members.pop_front());
    end
  endtask

  task automatic test_backpressure();
    op_result_t res;
    sender_steady = 1'b1;
    @(posedge clk);
    hold_seq++;
    repeat (12)
      send_op(vqfl_pkg::op_t'($urandom_range(0, 2)), rand_idx(), rand_idx(),
              1'($urandom_range(0, 1)), res);
    sender_steady = 1'b0;
  endtask

  task automatic test_pause_drain();
    op_result_t res;
    repeat (6) send_op(vqfl_pkg::OP_ALLOC, rand_idx(), rand_idx(), 1'b1, res);
    @(negedge clk) in_ch.valid = 1'b0;
    wait_for_results();
    send_op(vqfl_pkg::OP_FREE, res.granted, rand_idx(), 1'b0, res);
  endtask

  task automatic test_random_traffic();
    op_result_t res;
    logic [IDX_W-1:0] chain_heads[$];
    logic [IDX_W-1:0] members[$];
    int pick, len, k;
    while (ops_issued < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
        members.delete();
        repeat (len) begin
          send_op(vqfl_pkg::OP_ALLOC, rand_idx(), rand_idx(), 1'($urandom_range(0, 1)), res);
          if (res.status == STATUS_DONE) members.push_back(res.granted);
        end
        for (k = 0; k + 1 < members.size(); k++)
          send_op(vqfl_pkg::OP_LINK, members[k], members[k + 1],
                  1'($urandom_range(0, 1)), res);
        if (members.size() != 0) chain_heads.push_back(members[0]);
      end else if (pick < 85) begin
        if (chain_heads.size() != 0) begin
          k = $urandom_range(0, chain_heads.size() - 1);
          send_op(vqfl_pkg::OP_FREE, chain_heads[k], rand_idx(),
                  1'($urandom_range(0, 1)), res);
          chain_heads.delete(k);
        end
      end else begin
        send_op(vqfl_pkg::op_t'($urandom_range(0, 3)), rand_idx(), rand_idx(),
                1'($urandom_range(0, 1)), res);
      end
    end
  endtask

  // receiver: changes stall style after each random-length phase
  int hold_left = 0;
  int hold_seen = 0;
  int stall_mode = 0;
  int phase_left = 0;
  int pattern_pos = 0;
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(50, 400);
      end
      phase_left--;
      pattern_pos = (pattern_pos + 1) % 5;
      case (stall_mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 99) < 60);
        2: out_ch.ready = (pattern_pos < 3);
        default: out_ch.ready = ($urandom_range(0, 99) < 15);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    op_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d granted %0d freed %0d remaining %0d",
               out_ch.status, out_ch.granted_index, out_ch.freed_cnt, out_ch.free_remaining);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.granted_index !== want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, out_ch.granted_index);
          mismatch_count++;
        end
        if (out_ch.freed_cnt !== want.freed) begin
          $error("freed_cnt: expected %0d, got %0d", want.freed, out_ch.freed_cnt);
          mismatch_count++;
        end
        if (out_ch.free_remaining !== want.remaining) begin
          $error("free_remaining: expected %0d, got %0d", want.remaining,
                 out_ch.free_remaining);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("virtqueue_descriptor_free_list: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = vqfl_pkg::OP_NOP;
    in_ch.index       = '0;
    in_ch.link_target = '0;
    in_ch.writable    = 1'b0;
    rst_n             = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      desc_next[i]     = IDX_W'(i + 1);
      desc_chained[i]  = 1'b0;
      desc_writable[i] = 1'b0;
    end
    list_head  = '0;
    list_count = QUEUE_DEPTH;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    test_directed();
    test_exhaust();
    test_backpressure();
    test_pause_drain();
    test_random_traffic();

    @(negedge clk) in_ch.valid = 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("virtqueue_descriptor_free_list: match");
    else
      $display("virtqueue_descriptor_free_list: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
